// ===== hdl/bmm_pkg.sv =====
package bmm_pkg;

  // Port field widths
  localparam int PIX_W        = 8;
  localparam int ACT_W        = 1;
  localparam int CFG_IDX_W    = 8;
  localparam int CFG_DATA_W   = 16;
  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 16;
  localparam int ROW_W        = HEIGHT_REG_W + 1;

  localparam logic [ACT_W-1:0] ACTION_PIXEL = 1'b0;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 8'd2;

  localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = 16'd480;
  localparam logic [HEIGHT_REG_W-1:0] HEIGHT_MIN   = 16'd3;
  localparam logic [WIDTH_REG_W-1:0]  WIDTH_MIN    = 11'd3;

  typedef enum logic [1:0] {
    MODE_ERODE  = 2'd0,
    MODE_DILATE = 2'd1,
    MODE_OPEN   = 2'd2,
    MODE_CLOSE  = 2'd3
  } mode_t;

  // Per-sample control handed to one filter stage
  typedef struct packed {
    logic push;    // sample enters the stage
    logic and_op;  // 1 erosion, 0 dilation
    logic top;     // row above-above is inside the image
    logic mid;     // row above is inside the image
    logic cur;     // sample carries data
    logic use_a;   // oldest window column is inside the image
    logic use_v;   // newest column takes part
  } stg_ctl_t;

endpackage

// ===== hdl/bmm_in_if.sv =====
interface bmm_in_if;
  import bmm_pkg::*;
  logic             valid;
  logic             ready;
  logic [ACT_W-1:0] action;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, action, pixel_in, input ready);
  modport sink (input valid, action, pixel_in, output ready);
endinterface

// ===== hdl/bmm_out_if.sv =====
interface bmm_out_if;
  import bmm_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_last;
  modport source (output valid, pixel_out, frame_last, input ready);
  modport sink (input valid, pixel_out, frame_last, output ready);
endinterface

// ===== hdl/bmm_cfg_if.sv =====
interface bmm_cfg_if;
  import bmm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/binary_morphology_3x3_core.sv =====
// An accepted item passes through the b and c pipeline registers to the output register.
// Throughput: one item per cycle; input ready drops only while a result waits
// unclaimed, since the whole pipeline advances as one.
// Each filter stage reads and writes its line memory once per sample.
// Reset (synchronous, active low): 640x480 erosion, frame counters cleared,
// pipeline emptied; line memories are not cleared.
module binary_morphology_3x3_core #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  bmm_cfg_if.sink          cfg_ch,
  bmm_in_if.sink           in_ch,
  bmm_out_if.source        out_ch
);
  import bmm_pkg::*;

  localparam int AW  = $clog2(MAX_WIDTH);
  localparam int CW  = $clog2(MAX_WIDTH + 1);
  localparam int WW  = (CW > WIDTH_REG_W) ? CW : WIDTH_REG_W;

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // Configuration
  logic [WIDTH_REG_W-1:0]  width_r;
  logic [HEIGHT_REG_W-1:0] height_r;
  mode_t                   mode_r;

  // Frame position of each stage
  logic [AW-1:0]    col0_r;
  logic [ROW_W-1:0] row0_r;
  logic [AW-1:0]    col1_r;
  logic [ROW_W-1:0] row1_r;

  // Pipeline
  logic       b_res_r;
  logic       b_last_r;
  pix_t       b_x_r;
  stg_ctl_t   b_ctl1_r;
  logic [AW-1:0] b_col1_r;
  logic       c_res_r;
  logic       c_last_r;
  pix_t       c_y0_r;
  logic       out_valid_r;
  logic [PIX_W-1:0] out_pixel_r;
  logic       out_last_r;

  logic [WW-1:0]           w_wide;
  logic [WW-1:0]           w_eff;
  logic [AW-1:0]           w_last;
  logic [HEIGHT_REG_W-1:0] h_eff;
  logic [ROW_W-1:0]        h17;
  logic [ROW_W-1:0]        h_p1;
  logic two;
  logic op0;
  logic op1;
  logic adv;
  logic accept;
  logic cfg_wr;
  logic cfg_hit;
  logic row0_lt_h;
  logic done0;
  logic done1;
  logic push0;
  logic push1;
  logic emit0;
  logic emit1;
  logic res_now;
  logic last_now;
  stg_ctl_t ctl0;
  stg_ctl_t ctl1;
  pix_t x_in;
  pix_t y0;
  pix_t y1;

  always_comb begin
    w_wide = WW'(width_r);
    if (w_wide < WW'(WIDTH_MIN)) begin
      w_eff = WW'(WIDTH_MIN);
    end else if (w_wide > WW'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = w_wide;
    end
    w_last = AW'(w_eff - WW'(1));
    h_eff  = (height_r < HEIGHT_MIN) ? HEIGHT_MIN : height_r;
    h17    = {1'b0, h_eff};
    h_p1   = h17 + ROW_W'(1);
  end

  assign two = (mode_r == MODE_OPEN) || (mode_r == MODE_CLOSE);
  assign op0 = (mode_r == MODE_ERODE) || (mode_r == MODE_OPEN);
  assign op1 = (mode_r == MODE_CLOSE);

  assign adv          = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = adv;
  assign accept       = in_ch.valid && adv;
  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid;
  assign cfg_hit      = cfg_wr && ((cfg_ch.index == REG_WIDTH) ||
                        (cfg_ch.index == REG_HEIGHT) || (cfg_ch.index == REG_MODE));

  // Decide at acceptance what each stage does with this item
  always_comb begin
    row0_lt_h = row0_r < h17;
    done0 = ((row0_r == h_p1) && (col0_r != '0)) || (row0_r > h_p1);
    done1 = ((row1_r == h_p1) && (col1_r != '0)) || (row1_r > h_p1);
    emit0 = (col0_r == '0) ? (row0_r >= ROW_W'(2)) : (row0_r >= ROW_W'(1));
    emit1 = (col1_r == '0) ? (row1_r >= ROW_W'(2)) : (row1_r >= ROW_W'(1));
    // drop drain ticks that arrive mid-frame
    push0 = row0_lt_h ? (in_ch.action == ACTION_PIXEL) : !done0;
    push1 = two && ((push0 && emit0) || (!row0_lt_h && done0 && !done1));
    res_now  = two ? (push1 && emit1) : (push0 && emit0);
    last_now = res_now && (two ? (row1_r == h_p1) : (row0_r == h_p1));

    ctl0.push   = accept && push0;
    ctl0.and_op = op0;
    ctl0.top    = row0_r >= ROW_W'(2);
    ctl0.mid    = row0_r >= ROW_W'(1);
    ctl0.cur    = row0_lt_h;
    ctl0.use_a  = col0_r != AW'(1);
    ctl0.use_v  = col0_r != '0;

    ctl1.push   = accept && push1;
    ctl1.and_op = op1;
    ctl1.top    = row1_r >= ROW_W'(2);
    ctl1.mid    = row1_r >= ROW_W'(1);
    ctl1.cur    = push0 && (row1_r < h17);
    ctl1.use_a  = col1_r != AW'(1);
    ctl1.use_v  = col1_r != '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      mode_r   <= MODE_ERODE;
      col0_r   <= '0;
      row0_r   <= '0;
      col1_r   <= '0;
      row1_r   <= '0;
    end else begin
      if (cfg_wr) begin
        unique case (cfg_ch.index)
          REG_WIDTH:  width_r  <= cfg_ch.data[WIDTH_REG_W-1:0];
          REG_HEIGHT: height_r <= cfg_ch.data[HEIGHT_REG_W-1:0];
          REG_MODE:   mode_r   <= mode_t'(cfg_ch.data[1:0]);
          default:    ;
        endcase
      end
      // restart the frame on a write to a known register or after its last item
      if (cfg_hit || (accept && last_now)) begin
        col0_r <= '0;
        row0_r <= '0;
        col1_r <= '0;
        row1_r <= '0;
      end else if (accept) begin
        if (push0) begin
          if (col0_r == w_last) begin
            col0_r <= '0;
            row0_r <= row0_r + ROW_W'(1);
          end else begin
            col0_r <= col0_r + AW'(1);
          end
        end
        if (push1) begin
          if (col1_r == w_last) begin
            col1_r <= '0;
            row1_r <= row1_r + ROW_W'(1);
          end else begin
            col1_r <= col1_r + AW'(1);
          end
        end
      end
    end
  end

  assign x_in = PIXEL_BITS'(in_ch.pixel_in);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_res_r     <= 1'b0;
      b_ctl1_r    <= '0;
      c_res_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      b_res_r     <= accept && res_now;
      b_ctl1_r    <= ctl1;
      c_res_r     <= b_res_r;
      out_valid_r <= c_res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_last_r    <= last_now;
      b_x_r       <= x_in;
      b_col1_r    <= col1_r;
      c_last_r    <= b_last_r;
      c_y0_r      <= y0;
      out_pixel_r <= PIX_W'(two ? y1 : c_y0_r);
      out_last_r  <= c_last_r;
    end
  end

  bmm_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_stage0 (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .issue_ctl (ctl0),
    .issue_col (col0_r),
    .x_in      (b_x_r),
    .y_out     (y0)
  );

  bmm_stage #(
    .MAX_WIDTH  (MAX_WIDTH),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_stage1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .issue_ctl (b_ctl1_r),
    .issue_col (b_col1_r),
    .x_in      (c_y0_r),
    .y_out     (y1)
  );

  assign out_ch.valid      = out_valid_r;
  assign out_ch.pixel_out  = out_pixel_r;
  assign out_ch.frame_last = out_last_r;

  a_single_stage_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !two |-> !ctl1.push)
    else $error("second stage fed in a single-stage mode");

  a_row0_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (row0_r < h_p1) || ((row0_r == h_p1) && (col0_r <= AW'(1))))
    else $error("first stage ran past the end of the frame");

  a_row1_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (row1_r < h_p1) || ((row1_r == h_p1) && (col1_r <= AW'(1))))
    else $error("second stage ran past the end of the frame");

  a_last_restart: assert property (@(posedge clk) disable iff (!rst_n)
    accept && last_now |=> (row0_r == '0) && (row1_r == '0))
    else $error("frame did not restart after its last item");

endmodule

// ===== hdl/bmm_stage.sv =====
module bmm_stage #(
  parameter int MAX_WIDTH  = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  bmm_pkg::stg_ctl_t            issue_ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0] issue_col,
  input  logic [PIXEL_BITS-1:0]        x_in,
  output logic [PIXEL_BITS-1:0]        y_out
);
  import bmm_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  typedef logic [PIXEL_BITS-1:0] pix_t;

  // Entry c holds {row r-2, row r-1} of column c
  logic [2*PIXEL_BITS-1:0] line_mem [MAX_WIDTH];

  stg_ctl_t                ctl_r;
  logic [AW-1:0]           col_r;
  logic [2*PIXEL_BITS-1:0] rd_r;
  pix_t                    win_a_r [3];
  pix_t                    win_b_r [3];

  pix_t neutral;
  pix_t v0;
  pix_t v1;
  pix_t v2;
  pix_t terms [9];
  pix_t and_all;
  pix_t or_all;

  always_comb begin
    neutral = ctl_r.and_op ? '1 : '0;
    v0 = ctl_r.top ? rd_r[2*PIXEL_BITS-1:PIXEL_BITS] : neutral;
    v1 = ctl_r.mid ? rd_r[PIXEL_BITS-1:0] : neutral;
    v2 = ctl_r.cur ? x_in : neutral;
    for (int i = 0; i < 3; i++) begin
      terms[i]     = ctl_r.use_a ? win_a_r[i] : neutral;
      terms[3 + i] = win_b_r[i];
    end
    terms[6] = ctl_r.use_v ? v0 : neutral;
    terms[7] = ctl_r.use_v ? v1 : neutral;
    terms[8] = ctl_r.use_v ? v2 : neutral;
    and_all = '1;
    or_all  = '0;
    for (int i = 0; i < 9; i++) begin
      and_all = and_all & terms[i];
      or_all  = or_all | terms[i];
    end
    y_out = ctl_r.and_op ? and_all : or_all;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= issue_ctl;
    end
  end

  // Consecutive samples hit different columns and width is at least three,
  // so a read never meets a pending write to the same entry.
  always_ff @(posedge clk) begin
    if (adv) begin
      col_r <= issue_col;
      if (issue_ctl.push) begin
        rd_r <= line_mem[issue_col];
      end
      if (ctl_r.push) begin
        line_mem[col_r] <= {v1, v2};
        win_a_r <= win_b_r;
        win_b_r[0] <= v0;
        win_b_r[1] <= v1;
        win_b_r[2] <= v2;
      end
    end
  end

endmodule

// ===== verif/tb_binary_morphology_3x3_core.sv =====
module tb_binary_morphology_3x3_core;
  import bmm_pkg::*;

  localparam int MAX_W          = 1024;
  localparam int SETTLE_CYCLES  = 8;
  localparam int HOLD_CYCLES    = 300;
  localparam int TIMEOUT_CYCLES = 2_000_000;
  localparam int RANDOM_ITEMS   = 600;

  localparam logic [ACT_W-1:0]     ACTION_DRAIN  = ~ACTION_PIXEL;
  localparam logic [PIX_W-1:0]     AND_NEUTRAL   = '1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_MODE + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

  typedef enum {SHADE_FLAT, SHADE_BRIGHT, SHADE_DARK, SHADE_EXTREME} shade_t;

  typedef struct packed {
    logic [PIX_W-1:0] pix;
    logic             last;
  } morph_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  bmm_cfg_if cfg_ch ();
  bmm_in_if  in_ch ();
  bmm_out_if out_ch ();

  binary_morphology_3x3_core u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Model of the filter: line stores, windows and frame position per stage
  logic [PIX_W-1:0]        line_store [2][2*MAX_W];
  logic [PIX_W-1:0]        window [2][6];
  int unsigned             col_pos [2];
  int unsigned             row_pos [2];
  int unsigned             px_count;
  logic [WIDTH_REG_W-1:0]  width_reg;
  logic [HEIGHT_REG_W-1:0] height_reg;
  mode_t                   mode_reg;
  bit                      frame_done;

  morph_result_t pending_px[$];
  int            n_errors;
  int unsigned   items_taken;
  int            src_idle_pct;
  int            snk_stall_pct;
  bit            hold_start;
  int            hold_cnt;

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (TIMEOUT_CYCLES) @(posedge clk);
    $display("tb_binary_morphology_3x3_core failed");
    $finish;
  end

  function automatic int unsigned frame_width();
    int unsigned w;
    w = width_reg;
    if (w < WIDTH_MIN) w = WIDTH_MIN;
    if (w > MAX_W) w = MAX_W;
    return w;
  endfunction

  function automatic int unsigned frame_height();
    int unsigned h;
    h = height_reg;
    if (h < HEIGHT_MIN) h = HEIGHT_MIN;
    return h;
  endfunction

  function automatic void clear_frame_state();
    foreach (window[k, i]) window[k][i] = '0;
    col_pos  = '{0, 0};
    row_pos  = '{0, 0};
    px_count = 0;
  endfunction

  function automatic void reset_morph_model();
    foreach (line_store[k, i]) line_store[k][i] = '0;
    width_reg  = WIDTH_RESET;
    height_reg = HEIGHT_RESET;
    mode_reg   = MODE_ERODE;
    frame_done = 1'b0;
    clear_frame_state();
  endfunction

  function automatic void apply_reg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_WIDTH:  width_reg = val[WIDTH_REG_W-1:0];
      REG_HEIGHT: height_reg = val[HEIGHT_REG_W-1:0];
      REG_MODE:   mode_reg = mode_t'(val[1:0]);
      default:    return;
    endcase
    clear_frame_state();
  endfunction

  function automatic logic [PIX_W-1:0] combine(input bit and_op, input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return and_op ? (a & b) : (a | b);
  endfunction

  function automatic bit stage_finished(input int k);
    int unsigned h;
    h = frame_height();
    return row_pos[k] > h + 1 || (row_pos[k] == h + 1 && col_pos[k] >= 1);
  endfunction

  // One sample into a stage; returns 1 when the stage emits a filtered pixel
  function automatic bit stage_feed(input int k, input bit and_op, input bit live,
                                    input logic [PIX_W-1:0] x, output logic [PIX_W-1:0] y);
    int unsigned w, h, c, r;
    logic [PIX_W-1:0] nv, top, mid, cur, acc;
    bit hit;
    w   = frame_width();
    h   = frame_height();
    c   = col_pos[k];
    r   = row_pos[k];
    nv  = and_op ? AND_NEUTRAL : '0;
    hit = 1'b0;
    if (c >= MAX_W) c = 0;
    top = (r >= 2) ? line_store[k][c] : nv;
    mid = (r >= 1) ? line_store[k][MAX_W + c] : nv;
    cur = (live && r < h) ? x : nv;
    acc = nv;
    if (c == 0) begin
      // last column of the previous row: only the two held columns take part
      if (r >= 2) begin
        for (int i = 0; i < 6; i++) acc = combine(and_op, acc, window[k][i]);
        hit = 1'b1;
      end
    end else if (r >= 1) begin
      if (c >= 2) begin
        for (int i = 0; i < 3; i++) acc = combine(and_op, acc, window[k][i]);
      end
      for (int i = 3; i < 6; i++) acc = combine(and_op, acc, window[k][i]);
      acc = combine(and_op, acc, top);
      acc = combine(and_op, acc, mid);
      acc = combine(and_op, acc, cur);
      hit = 1'b1;
    end
    for (int i = 0; i < 3; i++) window[k][i] = window[k][i + 3];
    window[k][3] = top;
    window[k][4] = mid;
    window[k][5] = cur;
    line_store[k][c] = mid;
    line_store[k][MAX_W + c] = cur;
    c++;
    if (c >= w) begin
      c = 0;
      r++;
    end
    col_pos[k] = c;
    row_pos[k] = r;
    y = acc;
    return hit;
  endfunction

  // Returns 0 when the block ignores the item
  function automatic bit predict_morph(input logic [ACT_W-1:0] act,
                                       input logic [PIX_W-1:0] pix);
    bit two, op0, op1, hit;
    logic [PIX_W-1:0] y;
    morph_result_t res;
    two = (mode_reg == MODE_OPEN || mode_reg == MODE_CLOSE);
    op0 = (mode_reg == MODE_ERODE || mode_reg == MODE_OPEN);
    op1 = (mode_reg == MODE_CLOSE);
    hit = 1'b0;
    y   = '0;
    if (row_pos[0] < frame_height()) begin
      if (act == ACTION_DRAIN) return 1'b0;
      hit = stage_feed(0, op0, 1'b1, pix, y);
      if (two && hit) hit = stage_feed(1, op1, 1'b1, y, y);
    end else if (!stage_finished(0)) begin
      hit = stage_feed(0, op0, 1'b0, '0, y);
      if (two && hit) hit = stage_feed(1, op1, 1'b1, y, y);
    end else if (two && !stage_finished(1)) begin
      hit = stage_feed(1, op1, 1'b0, '0, y);
    end
    if (hit) begin
      px_count++;
      res.pix  = y;
      res.last = (px_count >= frame_width() * frame_height());
      pending_px.push_back(res);
      if (res.last) begin
        clear_frame_state();
        frame_done = 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [PIX_W-1:0] pick_pixel(input shade_t s);
    logic [PIX_W-1:0] v;
    case (s)
      SHADE_BRIGHT: v = PIX_W'($urandom | $urandom | $urandom);
      SHADE_DARK:   v = PIX_W'($urandom & $urandom & $urandom);
      SHADE_EXTREME: begin
        case ($urandom_range(3))
          0:       v = '0;
          1:       v = '1;
          2:       v = 8'h55;
          default: v = 8'haa;
        endcase
      end
      default:      v = PIX_W'($urandom);
    endcase
    return v;
  endfunction

  task automatic push_item(input logic [ACT_W-1:0] act, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid    <= 1'b1;
    in_ch.action   <= act;
    in_ch.pixel_in <= pix;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (predict_morph(act, pix)) items_taken++;
  endtask

  // Hold the input until every result is out and the pipeline has emptied
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    apply_reg(idx, val);
  endtask

  // Feed the rest of the frame, or only cut pixels of it when cut >= 0
  task automatic send_frame(input int cut, input int drain_pct, input shade_t shade);
    int sent;
    sent = 0;
    frame_done = 1'b0;
    while (row_pos[0] < frame_height() && (cut < 0 || sent < cut)) begin
      if ($urandom_range(99) < drain_pct) begin
        push_item(ACTION_DRAIN, PIX_W'($urandom));
      end else begin
        push_item(ACTION_PIXEL, pick_pixel(shade));
        sent++;
      end
    end
    if (row_pos[0] < frame_height()) return;
    // surplus pixels act as drain ticks
    while (!frame_done) begin
      push_item(($urandom_range(99) < 25) ? ACTION_PIXEL : ACTION_DRAIN, PIX_W'($urandom));
    end
  endtask

  task automatic set_idling(input int src_pct, input int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
  endtask

  task automatic test_reset_values();
    set_idling(0, 0);
    repeat (660) push_item(ACTION_PIXEL, pick_pixel(SHADE_BRIGHT));
  endtask

  task automatic test_corner_frames();
    mode_t m;
    write_reg(REG_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_HEIGHT, CFG_DATA_W'(3));
    m = m.first();
    repeat (4) begin
      write_reg(REG_MODE, CFG_DATA_W'(m));
      send_frame(-1, 20, SHADE_EXTREME);
      m = m.next();
    end
    // undersized dimensions clamp to the minimum
    write_reg(REG_WIDTH, '0);
    write_reg(REG_HEIGHT, CFG_DATA_W'(2));
    send_frame(-1, 0, SHADE_FLAT);
    write_reg(REG_WIDTH, CFG_DATA_W'(2));
    write_reg(REG_HEIGHT, '0);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_CLOSE));
    send_frame(-1, 0, SHADE_EXTREME);
    write_reg(REG_WIDTH, CFG_DATA_W'(1));
    write_reg(REG_HEIGHT, CFG_DATA_W'(1));
    write_reg(REG_MODE, CFG_DATA_W'(MODE_OPEN));
    send_frame(-1, 0, SHADE_EXTREME);
  endtask

  task automatic test_register_restart();
    write_reg(REG_WIDTH, CFG_DATA_W'(5));
    write_reg(REG_HEIGHT, CFG_DATA_W'(4));
    write_reg(REG_MODE, CFG_DATA_W'(MODE_DILATE));
    // writes to unknown indexes must leave the frame running
    send_frame(12, 0, SHADE_FLAT);
    write_reg(REG_UNUSED_LO, CFG_DATA_W'($urandom));
    write_reg(REG_UNUSED_HI, CFG_DATA_W'($urandom));
    send_frame(-1, 10, SHADE_FLAT);
    // a real write drops the partial frame
    send_frame(9, 0, SHADE_FLAT);
    write_reg(REG_HEIGHT, CFG_DATA_W'(4));
    send_frame(-1, 0, SHADE_FLAT);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_OPEN));
    send_frame(14, 0, SHADE_BRIGHT);
    write_reg(REG_WIDTH, CFG_DATA_W'(5));
    send_frame(-1, 0, SHADE_BRIGHT);
  endtask

  task automatic test_large_frames();
    set_idling(0, 0);
    write_reg(REG_WIDTH, '1);
    write_reg(REG_HEIGHT, CFG_DATA_W'(3));
    write_reg(REG_MODE, CFG_DATA_W'(MODE_ERODE));
    send_frame(MAX_W + 40, 0, SHADE_BRIGHT);
    write_reg(REG_WIDTH, CFG_DATA_W'(3));
    write_reg(REG_HEIGHT, '1);
    write_reg(REG_MODE, CFG_DATA_W'(MODE_DILATE));
    send_frame(40, 0, SHADE_DARK);
  endtask

  task automatic test_backpressure();
    set_idling(0, 0);
    write_reg(REG_WIDTH, CFG_DATA_W'(6));
    write_reg(REG_HEIGHT, CFG_DATA_W'(5));
    write_reg(REG_MODE, CFG_DATA_W'(MODE_OPEN));
    hold_start = 1'b1;
    send_frame(-1, 0, SHADE_FLAT);
    // pause mid-frame until the output has caught up
    send_frame(15, 5, SHADE_FLAT);
    in_ch.valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    @(posedge clk);
    send_frame(-1, 5, SHADE_FLAT);
  endtask

  task automatic test_random_traffic();
    int src_pcts [4];
    int snk_pcts [4];
    int unsigned start, w, h, cut;
    bit restart_due;
    src_pcts = '{0, 53, 0, 38};
    snk_pcts = '{0, 0, 53, 38};
    restart_due = 1'b0;
    for (int p = 0; p < 4; p++) begin
      set_idling(src_pcts[p], snk_pcts[p]);
      start = items_taken;
      while (items_taken - start < RANDOM_ITEMS / 4) begin
        if (restart_due || $urandom_range(99) < 60) begin
          if ($urandom_range(99) < 8) w = $urandom_range(2);
          else if ($urandom_range(99) < 85) w = $urandom_range(10, 3);
          else w = $urandom_range(64, 11);
          write_reg(REG_WIDTH, CFG_DATA_W'({5'($urandom), 11'(w)}));
        end
        if ($urandom_range(99) < 60) begin
          if ($urandom_range(99) < 8) h = $urandom_range(2);
          else if ($urandom_range(99) < 85) h = $urandom_range(6, 3);
          else h = $urandom_range(16, 7);
          write_reg(REG_HEIGHT, CFG_DATA_W'(h));
        end
        if (restart_due || $urandom_range(99) < 60) begin
          write_reg(REG_MODE, CFG_DATA_W'($urandom));
        end
        if ($urandom_range(99) < 5) begin
          write_reg(CFG_IDX_W'($urandom_range(REG_UNUSED_HI, REG_UNUSED_LO)),
                    CFG_DATA_W'($urandom));
        end
        restart_due = 1'b0;
        if ($urandom_range(99) < 8) begin
          cut = $urandom_range(frame_width() * frame_height() - 1, 1);
          send_frame(cut, $urandom_range(15), shade_t'($urandom_range(3)));
          restart_due = 1'b1;
        end else begin
          send_frame(-1, $urandom_range(15), shade_t'($urandom_range(3)));
        end
      end
    end
  endtask

  // Result side: random stalls, or a long hold when one is requested
  always @(posedge clk) begin
    if (hold_start) begin
      hold_start = 1'b0;
      hold_cnt   = HOLD_CYCLES;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  always @(posedge clk) begin
    morph_result_t want;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_px.size() == 0) begin
        $error("unexpected item: pixel_out %0h frame_last %0b",
               out_ch.pixel_out, out_ch.frame_last);
        n_errors++;
      end else begin
        want = pending_px.pop_front();
        if (out_ch.pixel_out !== want.pix) begin
          $error("pixel_out mismatch: expected %0h, actual %0h", want.pix, out_ch.pixel_out);
          n_errors++;
        end
        if (out_ch.frame_last !== want.last) begin
          $error("frame_last mismatch: expected %0b, actual %0b", want.last,
                 out_ch.frame_last);
          n_errors++;
        end
      end
    end
  end

  initial begin
    in_ch.valid    = 1'b0;
    in_ch.action   = ACTION_PIXEL;
    in_ch.pixel_in = '0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = REG_WIDTH;
    cfg_ch.data    = '0;
    out_ch.ready   = 1'b0;
    n_errors       = 0;
    items_taken    = 0;
    hold_start     = 1'b0;
    hold_cnt       = 0;
    set_idling(0, 0);
    reset_morph_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_corner_frames();
    test_register_restart();
    test_large_frames();
    test_backpressure();
    test_random_traffic();

    settle();
    repeat (20) @(posedge clk);
    if (n_errors == 0) begin
      $display("tb_binary_morphology_3x3_core passed");
    end else begin
      $display("tb_binary_morphology_3x3_core failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bmm_pkg.sv
hdl/bmm_in_if.sv
hdl/bmm_out_if.sv
hdl/bmm_cfg_if.sv
hdl/bmm_stage.sv
hdl/binary_morphology_3x3_core.sv
verif/tb_binary_morphology_3x3_core.sv
